FILE: rtl/scrs_pkg.sv
// Shared types and constants for the sorted coordinate range search unit.
package scrs_pkg;

    localparam int POINTS_MAX   = 512;
    localparam int SEARCH_STEPS = 16;

    localparam int IDX_W  = $clog2(POINTS_MAX);
    localparam int CNT_W  = 10;
    localparam int X_W    = 10;
    localparam int END_W  = X_W + 1;
    localparam int STEP_W = $clog2(SEARCH_STEPS);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [8:0]       point_index;
        logic [X_W-1:0]   point_x;
        logic [X_W-1:0]   window_start;
        logic [X_W-1:0]   window_end;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [8:0] first_index;
        logic [8:0] last_index;
    } res_t;

    typedef struct packed {
        logic below_start;
        logic at_or_past_end;
    } cmp_flags_t;

endpackage

FILE: rtl/sorted_coordinate_range_search_unit.sv
// Top level: sequencer that runs the range search over the coordinate table.
// A write item is written on acceptance, and a query with fewer than two points strobes its result in the
// cycle after acceptance; neither raises busy. Any other query holds busy until its result is ready,
// as the single table read port needs an address state and a compare state per read: B <= 16
// search reads, C <= 2 end checks, L and R the walk reads, and an address state with no compare
// for each walk that stops at a table end. The one-cycle result strobe follows busy and the receiver cannot stall it.
// Reset clears the sequencer and sets count_reg to 101; the table is not cleared.
module sorted_coordinate_range_search_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  scrs_pkg::req_t            req,
    input  logic                      cfg_we,
    input  logic [scrs_pkg::CNT_W-1:0] cfg_wdata,
    output logic                      res_strobe,
    output scrs_pkg::res_t            res
);
    import scrs_pkg::*;

    // The sequencer: binary search, then tail and head checks, then the walk
    // to the left and to the right. Each read has an issue state and an
    // evaluate state, since the table data is registered and comes back in the next cycle.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BS_RD,
        ST_BS_EV,
        ST_TL_RD,
        ST_TL_EV,
        ST_HD_RD,
        ST_HD_EV,
        ST_LW_RD,
        ST_LW_EV,
        ST_RW_RD,
        ST_RW_EV
    } state_t;

    localparam logic [CNT_W-1:0] N_CAP = CNT_W'(POINTS_MAX);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SEARCH_STEPS - 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [X_W-1:0]      start_reg, start_next;
    logic [END_W-1:0]    end_reg, end_next;
    // During the search these hold head and tail; during the walk they hold
    // the left and right ends of the range found so far.
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [IDX_W-1:0]    mid_reg, mid_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                strobe_reg, strobe_next;
    res_t                res_reg, res_next;

    logic                accept;
    logic                mem_we;
    logic [IDX_W-1:0]    raddr;
    logic [X_W-1:0]      rdata;
    cmp_flags_t          flags;
    logic                in_win;
    logic [CNT_W-1:0]    mid_sum;
    logic [CNT_W-1:0]    right_plus;
    logic [CNT_W-1:0]    n_sat;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign mem_we = accept && (req.req_type == REQ_WRITE);

    assign mid_sum    = {1'b0, head_reg} + {1'b0, tail_reg};
    assign right_plus = {1'b0, tail_reg} + CNT_W'(1);
    assign n_sat      = (count_reg > N_CAP) ? N_CAP : count_reg;
    assign in_win     = !flags.below_start && !flags.at_or_past_end;

    // Table read address for the current issue state.
    always_comb
    begin
        unique case (state_reg)
            ST_BS_RD: raddr = mid_sum[IDX_W:1];
            ST_TL_RD: raddr = tail_reg;
            ST_HD_RD: raddr = head_reg;
            ST_LW_RD: raddr = head_reg - IDX_W'(1);
            ST_RW_RD: raddr = right_plus[IDX_W-1:0];
            default:  raddr = mid_reg;
        endcase
    end

    scrs_coord_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (req.point_index),
        .wdata (req.point_x),
        .raddr (raddr),
        .rdata (rdata)
    );

    scrs_window_cmp u_cmp (
        .px        (rdata),
        .win_start (start_reg),
        .win_end   (end_reg),
        .flags     (flags)
    );

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        mid_next    = mid_reg;
        step_next   = step_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_QUERY))
                begin
                    n_next     = n_sat;
                    start_next = req.window_start;
                    // An empty or inverted window has its end raised by one pixel; an inverted one stays empty.
                    if (req.window_end <= req.window_start)
                    begin
                        end_next = {1'b0, req.window_end} + END_W'(1);
                    end
                    else
                    begin
                        end_next = {1'b0, req.window_end};
                    end
                    head_next = '0;
                    tail_next = IDX_W'(n_sat - CNT_W'(1));
                    step_next = '0;
                    if (n_sat < CNT_W'(2))
                    begin
                        strobe_next = 1'b1;
                        res_next    = '0;
                    end
                    else
                    begin
                        state_next = ST_BS_RD;
                    end
                end
            end

            ST_BS_RD:
            begin
                mid_next   = mid_sum[IDX_W:1];
                state_next = ST_BS_EV;
            end

            ST_BS_EV:
            begin
                if (in_win)
                begin
                    head_next  = mid_reg;
                    tail_next  = mid_reg;
                    state_next = ST_LW_RD;
                end
                else if (flags.at_or_past_end && (mid_reg == tail_reg))
                begin
                    state_next = ST_TL_RD;
                end
                else if (!flags.at_or_past_end && (mid_reg == head_reg))
                begin
                    state_next = ST_TL_RD;
                end
                else
                begin
                    if (flags.at_or_past_end)
                    begin
                        tail_next = mid_reg;
                    end
                    else
                    begin
                        head_next = mid_reg;
                    end
                    step_next  = step_reg + STEP_W'(1);
                    state_next = (step_reg == STEP_LAST) ? ST_TL_RD : ST_BS_RD;
                end
            end

            ST_TL_RD:
            begin
                state_next = ST_TL_EV;
            end

            ST_TL_EV:
            begin
                if (in_win)
                begin
                    head_next  = tail_reg;
                    state_next = ST_LW_RD;
                end
                else
                begin
                    state_next = ST_HD_RD;
                end
            end

            ST_HD_RD:
            begin
                state_next = ST_HD_EV;
            end

            ST_HD_EV:
            begin
                if (in_win)
                begin
                    tail_next  = head_reg;
                    state_next = ST_LW_RD;
                end
                else
                begin
                    strobe_next = 1'b1;
                    res_next    = '0;
                    state_next  = ST_IDLE;
                end
            end

            ST_LW_RD:
            begin
                state_next = (head_reg == '0) ? ST_RW_RD : ST_LW_EV;
            end

            ST_LW_EV:
            begin
                if (!flags.below_start)
                begin
                    head_next  = head_reg - IDX_W'(1);
                    state_next = ST_LW_RD;
                end
                else
                begin
                    state_next = ST_RW_RD;
                end
            end

            ST_RW_RD:
            begin
                if (right_plus >= n_reg)
                begin
                    strobe_next          = 1'b1;
                    res_next.found       = 1'b1;
                    res_next.first_index = head_reg;
                    res_next.last_index  = tail_reg;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RW_EV;
                end
            end

            ST_RW_EV:
            begin
                if (!flags.at_or_past_end)
                begin
                    tail_next  = right_plus[IDX_W-1:0];
                    state_next = ST_RW_RD;
                end
                else
                begin
                    strobe_next          = 1'b1;
                    res_next.found       = 1'b1;
                    res_next.first_index = head_reg;
                    res_next.last_index  = tail_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= CNT_W'(101);
            n_reg      <= '0;
            start_reg  <= '0;
            end_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            mid_reg    <= '0;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            n_reg      <= n_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            mid_reg    <= mid_next;
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
            res_reg    <= res_next;
        end
    end

    assign res_strobe = strobe_reg;
    assign res        = res_reg;

endmodule

FILE: rtl/scrs_coord_mem.sv
// Coordinate table: one write port and one registered read port.
module scrs_coord_mem (
    input  logic                     clk,
    input  logic                     we,
    input  logic [scrs_pkg::IDX_W-1:0] waddr,
    input  logic [scrs_pkg::X_W-1:0]   wdata,
    input  logic [scrs_pkg::IDX_W-1:0] raddr,
    output logic [scrs_pkg::X_W-1:0]   rdata
);
    import scrs_pkg::*;

    logic [X_W-1:0] mem [POINTS_MAX];
    logic [X_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/scrs_window_cmp.sv
// Shared window comparator applied to every coordinate read from the table.
module scrs_window_cmp (
    input  logic [scrs_pkg::X_W-1:0]   px,
    input  logic [scrs_pkg::X_W-1:0]   win_start,
    input  logic [scrs_pkg::END_W-1:0] win_end,
    output scrs_pkg::cmp_flags_t       flags
);
    import scrs_pkg::*;

    always_comb
    begin
        flags.below_start    = (px < win_start);
        flags.at_or_past_end = ({1'b0, px} >= win_end);
    end

endmodule
